FILE: design/kvt_pkg.sv
// Shared types, constants and key/value normalization for the key-value table.
package kvt_pkg;

    localparam int ENTRIES     = 16;
    localparam int KEY_BYTES   = 8;
    localparam int VALUE_BYTES = 8;

    localparam int DATA_W      = 64;
    localparam int COUNT_W     = $clog2(ENTRIES + 1);
    localparam int ENTRY_CNT_W = 5;

    // opcodes
    localparam logic [1:0] OP_LOOKUP = 2'd0;
    localparam logic [1:0] OP_ADD    = 2'd1;
    localparam logic [1:0] OP_UPDATE = 2'd2;
    localparam logic [1:0] OP_REMOVE = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_PRESENT   = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    typedef logic [DATA_W-1:0]  t_data;
    typedef logic [COUNT_W-1:0] t_count;

    // Broadcast to every cell while an operation executes.
    typedef struct packed {
        logic       exec;
        logic [1:0] opcode;
        logic       hit;
        t_data      key;
        t_data      value;
    } t_cell_cmd;

    // Per-cell position relative to the fill count.
    typedef struct packed {
        logic live;   // cell holds an entry
        logic tail;   // cell is the first free slot
    } t_cell_pos;

    // Keep the low nbytes bytes and clear every byte after the first zero byte.
    function automatic t_data normalize(input t_data x, input int nbytes);
        t_data r;
        logic  stop;
        r    = '0;
        stop = 1'b0;
        for (int b = 0; b < DATA_W / 8; b++) begin
            if (b >= nbytes || x[8*b +: 8] == 8'h00) begin
                stop = 1'b1;
            end
            if (!stop) begin
                r[8*b +: 8] = x[8*b +: 8];
            end
        end
        return r;
    endfunction

    // Fill count reported on the fixed 5-bit field.
    function automatic logic [ENTRY_CNT_W-1:0] count_field(input t_count c);
        logic [31:0] wide;
        wide = 32'(c);
        return wide[ENTRY_CNT_W-1:0];
    endfunction

endpackage

FILE: design/key_value_table.sv
// Top level of the key-value table: input capture, cell row and result register.
//
// Usage
//   Input channel: i_in_valid / o_in_stall carry one item (i_opcode, i_key,
//   i_value). Output channel: o_out_valid / i_out_stall carry one result
//   (o_status, o_found, o_value_out, o_entry_count) per item.
//   The capture register takes the item and normalizes key and value (bytes after the
//   first zero byte are cleared). The execute step broadcasts it to the row of cells:
//   every cell compares its key in parallel, and the selected cells append,
//   overwrite, or shift down from their upper neighbor in that same edge,
//   so a remove compacts the whole row at once. The result lands in the
//   output register on that same edge. A new item is taken only once the last one
//   has executed, since the capture and execute steps share the single cell row.
//   While the result waits, the next item is still taken; it then holds in
//   the capture register until the output register frees, so a stalled
//   receiver stops the block after one more item.
//   Reset clears the fill count and both valid flags; cell contents are not
//   cleared, since only cells below the fill count are ever compared.
module key_value_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_opcode,
    input  logic [63:0] i_key,
    input  logic [63:0] i_value,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic        o_found,
    output logic [63:0] o_value_out,
    output logic [4:0]  o_entry_count
);
    import kvt_pkg::*;

    // capture stage
    logic       r_busy;
    logic [1:0] r_op;
    t_data      r_key;
    t_data      r_value;

    // table state
    t_count     r_count;
    t_count     n_count;

    // result register
    logic       r_out_valid;
    logic [1:0] r_status;
    logic       r_found;
    t_data      r_value_out;
    logic [ENTRY_CNT_W-1:0] r_entry_count;

    logic       in_take;
    logic       exec;
    logic       hit;
    logic       full;
    logic [1:0] n_status;
    t_data      hit_value;
    t_cell_cmd  cmd;

    t_cell_pos  pos       [ENTRIES];
    logic       seen      [ENTRIES+1];
    logic       match     [ENTRIES];
    t_data      cell_key  [ENTRIES];
    t_data      cell_val  [ENTRIES];
    t_data      next_key  [ENTRIES];
    t_data      next_val  [ENTRIES];

    assign o_in_stall = r_busy;
    assign in_take    = i_in_valid && !r_busy;
    // execute once the result register is free or being emptied
    assign exec       = r_busy && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (in_take) begin
            r_busy <= 1'b1;
        end else if (exec) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_op    <= i_opcode;
            r_key   <= normalize(i_key, KEY_BYTES);
            r_value <= normalize(i_value, VALUE_BYTES);
        end
    end

    // the match chain also ripples a "seen" flag up the row for compaction
    assign seen[0] = 1'b0;
    assign hit     = seen[ENTRIES];
    assign full    = (r_count == t_count'(ENTRIES));

    assign cmd.exec   = exec;
    assign cmd.opcode = r_op;
    assign cmd.hit    = hit;
    assign cmd.key    = r_key;
    assign cmd.value  = r_value;

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        assign pos[g].live = (t_count'(g) < r_count);
        assign pos[g].tail = (t_count'(g) == r_count);
        if (g == ENTRIES - 1) begin : g_last
            // top cell has no neighbor above: keep its own contents
            assign next_key[g] = cell_key[g];
            assign next_val[g] = cell_val[g];
        end else begin : g_mid
            assign next_key[g] = cell_key[g+1];
            assign next_val[g] = cell_val[g+1];
        end

        kvt_cell u_cell (
            .i_clk        (i_clk),
            .i_cmd        (cmd),
            .i_pos        (pos[g]),
            .i_seen       (seen[g]),
            .i_next_key   (next_key[g]),
            .i_next_value (next_val[g]),
            .o_seen       (seen[g+1]),
            .o_match      (match[g]),
            .o_key        (cell_key[g]),
            .o_value      (cell_val[g])
        );
    end

    // keys are unique in the table, so at most one cell matches
    always_comb begin
        hit_value = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (match[i]) begin
                hit_value = hit_value | cell_val[i];
            end
        end
    end

    always_comb begin
        n_count  = r_count;
        n_status = ST_OK;
        case (r_op)
            OP_LOOKUP: begin
                if (!hit) begin
                    n_status = ST_NOT_FOUND;
                end
            end
            OP_ADD: begin
                if (hit) begin
                    n_status = ST_PRESENT;
                end else if (full) begin
                    n_status = ST_FULL;
                end else begin
                    n_count = r_count + t_count'(1);
                end
            end
            OP_UPDATE: begin
                if (!hit) begin
                    n_status = ST_NOT_FOUND;
                end
            end
            OP_REMOVE: begin
                if (hit) begin
                    n_count = r_count - t_count'(1);
                end else begin
                    n_status = ST_NOT_FOUND;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (exec) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec) begin
            r_status      <= n_status;
            r_found       <= hit;
            r_value_out   <= (r_op == OP_LOOKUP && hit) ? hit_value : '0;
            r_entry_count <= count_field(n_count);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_found       = r_found;
    assign o_value_out   = r_value_out;
    assign o_entry_count = r_entry_count;

endmodule

FILE: design/kvt_cell.sv
// One table slot: holds a key and value, compares, and shifts down from its neighbor.
module kvt_cell (
    input  logic               i_clk,
    input  kvt_pkg::t_cell_cmd i_cmd,
    input  kvt_pkg::t_cell_pos i_pos,
    input  logic               i_seen,
    input  kvt_pkg::t_data     i_next_key,
    input  kvt_pkg::t_data     i_next_value,
    output logic               o_seen,
    output logic               o_match,
    output kvt_pkg::t_data     o_key,
    output kvt_pkg::t_data     o_value
);
    import kvt_pkg::*;

    t_data r_key;
    t_data r_value;
    t_data n_key;
    t_data n_value;

    assign o_match = i_pos.live && (r_key == i_cmd.key);
    assign o_seen  = i_seen | o_match;
    assign o_key   = r_key;
    assign o_value = r_value;

    always_comb begin
        n_key   = r_key;
        n_value = r_value;
        if (i_cmd.exec) begin
            case (i_cmd.opcode)
                OP_ADD: begin
                    if (!i_cmd.hit && i_pos.tail) begin
                        n_key   = i_cmd.key;
                        n_value = i_cmd.value;
                    end
                end
                OP_UPDATE: begin
                    if (o_match) begin
                        n_value = i_cmd.value;
                    end
                end
                OP_REMOVE: begin
                    // close the gap: this cell and every later one take the next entry
                    if (i_cmd.hit && o_seen) begin
                        n_key   = i_next_key;
                        n_value = i_next_value;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_key   <= n_key;
        r_value <= n_value;
    end

endmodule

FILE: sim/tb_key_value_table.sv
// Self-checking testbench for key_value_table: shadow table, random traffic and stall patterns.
module tb_key_value_table;
    import kvt_pkg::*;

    localparam int POOL_SIZE    = 24;
    localparam int RANDOM_ITEMS = 800;
    localparam int DRAIN_LIMIT  = 20000;
    localparam int SETTLE       = 8;

    // Receiver stall behavior, picked anew for each stretch of cycles.
    typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} t_rx_mode;
    // Opcode mix of one random phase: grow the table, keep it level, or shrink it.
    typedef enum int {MIX_FILL, MIX_EVEN, MIX_DRAIN} t_op_mix;

    typedef struct packed {
        logic [1:0]             status;
        logic                   found;
        t_data                  value_out;
        logic [ENTRY_CNT_W-1:0] entry_count;
    } t_kv_reply;

    // Shadow copy of the table: predicts the reply of every accepted item and
    // checks the replies that come back, oldest first.
    class kv_table_shadow;
        t_data       key_cells[ENTRIES];
        t_data       value_cells[ENTRIES];
        int unsigned fill = 0;
        int unsigned errors = 0;
        t_kv_reply   due_replies[$];

        // Keep the low nbytes bytes, up to but not including the first zero byte.
        static function t_data keep_prefix(t_data x, int nbytes);
            t_data r;
            r = '0;
            for (int b = 0; b < nbytes && b < 8; b++) begin
                if (x[8*b +: 8] == 8'h00) break;
                r[8*b +: 8] = x[8*b +: 8];
            end
            return r;
        endfunction

        function void note_request(logic [1:0] op, t_data raw_key, t_data raw_value);
            t_data       k;
            t_data       v;
            int unsigned idx;
            logic        hit;
            t_kv_reply   r;
            k   = keep_prefix(raw_key, KEY_BYTES);
            v   = keep_prefix(raw_value, VALUE_BYTES);
            idx = fill;
            for (int unsigned i = 0; i < fill; i++) begin
                if (key_cells[i] == k) begin
                    idx = i;
                    break;
                end
            end
            hit      = (idx < fill);
            r        = '0;
            r.status = ST_OK;
            r.found  = hit;
            case (op)
                OP_LOOKUP: begin
                    if (hit) r.value_out = value_cells[idx];
                    else     r.status = ST_NOT_FOUND;
                end
                OP_ADD: begin
                    if (hit) begin
                        r.status = ST_PRESENT;
                    end else if (fill >= ENTRIES) begin
                        r.status = ST_FULL;
                    end else begin
                        key_cells[fill]   = k;
                        value_cells[fill] = v;
                        fill++;
                    end
                end
                OP_UPDATE: begin
                    if (hit) value_cells[idx] = v;
                    else     r.status = ST_NOT_FOUND;
                end
                default: begin
                    if (hit) begin
                        for (int unsigned i = idx; i + 1 < fill; i++) begin
                            key_cells[i]   = key_cells[i+1];
                            value_cells[i] = value_cells[i+1];
                        end
                        fill--;
                    end else begin
                        r.status = ST_NOT_FOUND;
                    end
                end
            endcase
            r.entry_count = ENTRY_CNT_W'(fill);
            due_replies.push_back(r);
        endfunction

        function void compare_field(string name, t_data exp, t_data got);
            if (exp !== got) begin
                errors++;
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp, got);
            end
        endfunction

        function void check_reply(t_kv_reply got);
            t_kv_reply exp;
            if (due_replies.size() == 0) begin
                errors++;
                $display("%0t: reply with nothing expected, actual %h", $time, got);
                return;
            end
            exp = due_replies.pop_front();
            compare_field("status", t_data'(exp.status), t_data'(got.status));
            compare_field("found", t_data'(exp.found), t_data'(got.found));
            compare_field("value_out", exp.value_out, got.value_out);
            compare_field("entry_count", t_data'(exp.entry_count), t_data'(got.entry_count));
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [1:0]  i_opcode;
    logic [63:0] i_key;
    logic [63:0] i_value;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [1:0]  o_status;
    logic        o_found;
    logic [63:0] o_value_out;
    logic [4:0]  o_entry_count;

    kv_table_shadow shadow;
    t_data          key_pool[POOL_SIZE];

    key_value_table i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_opcode      (i_opcode),
        .i_key         (i_key),
        .i_value       (i_value),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_found       (o_found),
        .o_value_out   (o_value_out),
        .o_entry_count (o_entry_count)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Present one item from a falling edge, hold it until a rising edge takes it,
    // note it in the shadow table, and return at the next falling edge.
    task automatic drive_item(logic [1:0] op, t_data key, t_data value);
        i_in_valid = 1'b1;
        i_opcode   = op;
        i_key      = key;
        i_value    = value;
        do @(posedge i_clk); while (o_in_stall);
        shadow.note_request(op, key, value);
        @(negedge i_clk);
    endtask

    // Drop valid for a gap; a zero gap leaves valid alone so back-to-back items stay high.
    task automatic hold_off(int cycles);
        if (cycles > 0) begin
            i_in_valid = 1'b0;
            repeat (cycles) @(negedge i_clk);
        end
    endtask

    // Fill the bytes above the first zero byte with junk: the normalized key is unchanged.
    function automatic t_data with_tail_noise(t_data x);
        int    p;
        t_data junk;
        p = 8;
        for (int b = 7; b >= 0; b--) begin
            if (x[8*b +: 8] == 8'h00) p = b;
        end
        junk = {$urandom, $urandom};
        if (p < 7 && $urandom_range(0, 1) == 1) begin
            x = x | (junk & ~((64'h1 << (8 * (p + 1))) - 64'h1));
        end
        return x;
    endfunction

    // Cut a random string short at a random byte, so short keys and values are common.
    function automatic t_data random_string(int cut_odds);
        t_data s;
        s = {$urandom, $urandom};
        if ($urandom_range(0, 99) < cut_odds) s[8*$urandom_range(0, 7) +: 8] = 8'h00;
        return s;
    endfunction

    // Mostly pool keys, so hits, duplicates and a full table happen; now and then a wild key.
    function automatic t_data pick_key();
        if ($urandom_range(0, 9) == 0) return {$urandom, $urandom};
        return with_tail_noise(key_pool[$urandom_range(0, POOL_SIZE - 1)]);
    endfunction

    function automatic logic [1:0] pick_op(t_op_mix mix);
        int roll;
        roll = $urandom_range(0, 99);
        case (mix)
            MIX_FILL: begin
                if (roll < 55)      return OP_ADD;
                else if (roll < 75) return OP_LOOKUP;
                else if (roll < 85) return OP_UPDATE;
                else                return OP_REMOVE;
            end
            MIX_DRAIN: begin
                if (roll < 50)      return OP_REMOVE;
                else if (roll < 70) return OP_LOOKUP;
                else if (roll < 85) return OP_ADD;
                else                return OP_UPDATE;
            end
            default: begin
                if (roll < 25)      return OP_LOOKUP;
                else if (roll < 50) return OP_ADD;
                else if (roll < 75) return OP_UPDATE;
                else                return OP_REMOVE;
            end
        endcase
    endfunction

    // Receiver: stall on a pattern of its own, changed after each random span of cycles,
    // with stretches of no stall at all.
    initial begin : out_stall_pattern
        t_rx_mode rx_mode;
        int       span;
        i_out_stall = 1'b0;
        forever begin
            rx_mode = t_rx_mode'($urandom_range(0, 3));
            span    = $urandom_range(8, 64);
            for (int c = 0; c < span; c++) begin
                @(negedge i_clk);
                case (rx_mode)
                    RX_FREE:  i_out_stall = 1'b0;
                    RX_LIGHT: i_out_stall = ($urandom_range(0, 3) == 0);
                    RX_HEAVY: i_out_stall = ($urandom_range(0, 3) != 0);
                    default:  i_out_stall = ((c % 6) < 2);
                endcase
            end
        end
    end

    // Check every reply taken at a rising edge against the oldest prediction.
    always @(posedge i_clk) begin : reply_monitor
        t_kv_reply got;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got.status      = o_status;
            got.found       = o_found;
            got.value_out   = o_value_out;
            got.entry_count = o_entry_count;
            shadow.check_reply(got);
        end
    end

    initial begin : stimulus
        int          sent;
        int          phase_left;
        int          burst;
        int          wait_cycles;
        t_op_mix     mix;
        logic [1:0]  op;

        shadow     = new();
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_opcode   = OP_LOOKUP;
        i_key      = '0;
        i_value    = '0;

        // Key pool: the all-zero key, the all-ones key, a short string, then random keys,
        // most of them cut short by a zero byte.
        key_pool[0] = '0;
        key_pool[1] = {64{1'b1}};
        key_pool[2] = 64'h0000_0000_0000_3231;
        for (int i = 3; i < POOL_SIZE; i++) key_pool[i] = random_string(60);

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Empty table: every lookup, update and remove misses.
        drive_item(OP_LOOKUP, 64'h0, 64'h0);
        drive_item(OP_UPDATE, 64'h0000_0000_0000_0041, 64'h1);
        drive_item(OP_REMOVE, {64{1'b1}}, 64'h0);
        // The all-zero key is a real key; an all-ones value keeps every byte.
        drive_item(OP_ADD, 64'h0, {64{1'b1}});
        drive_item(OP_ADD, {64{1'b1}}, 64'h0);
        hold_off(3);
        // Bytes after the first zero byte count for nothing, in key or value.
        drive_item(OP_ADD, 64'h00FF_FFFF_0000_3231, 64'h0000_00AA_0055_4433);
        drive_item(OP_ADD, 64'h0000_0000_0000_3231, 64'h5);
        drive_item(OP_LOOKUP, 64'h1234_5600_0000_3231, 64'h0);
        drive_item(OP_UPDATE, 64'h0, 64'h8000_0000_0000_0001);
        drive_item(OP_LOOKUP, 64'hA5A5_0000_0000_0000, {64{1'b1}});
        // Remove from the middle, then find the entry that moved down.
        drive_item(OP_REMOVE, {64{1'b1}}, {64{1'b1}});
        drive_item(OP_LOOKUP, 64'h0000_0000_0000_3231, 64'h0);
        hold_off(1);
        // Fill to capacity with one-byte keys.
        for (int b = 3; b <= 16; b++) drive_item(OP_ADD, t_data'(b), {$urandom, $urandom});
        // Full table: a new key is refused, a present key reports present first.
        drive_item(OP_ADD, 64'h77, 64'h1);
        drive_item(OP_ADD, 64'h0, 64'h1);
        drive_item(OP_LOOKUP, 64'h10, 64'h0);
        // Remove the first entry (whole row shifts) and the last one.
        drive_item(OP_REMOVE, 64'h0, 64'h0);
        drive_item(OP_REMOVE, 64'h10, 64'h0);
        drive_item(OP_ADD, 64'h77, 64'hFFFF_0000_FFFF_FFFF);

        // Random phases, each with its own opcode mix, sent in bursts with gaps.
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            mix        = t_op_mix'($urandom_range(0, 2));
            phase_left = $urandom_range(30, 90);
            while (phase_left > 0 && sent < RANDOM_ITEMS) begin
                burst = $urandom_range(1, 24);
                repeat (burst) begin
                    op = pick_op(mix);
                    drive_item(op, pick_key(), random_string(30));
                    sent++;
                    phase_left--;
                end
                if ($urandom_range(0, 3) != 0) hold_off($urandom_range(1, 6));
            end
        end
        i_in_valid = 1'b0;

        // Drain: wait for every predicted reply, then wait on for strays.
        wait_cycles = 0;
        while (shadow.due_replies.size() != 0 && wait_cycles < DRAIN_LIMIT) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (SETTLE) @(posedge i_clk);

        if (shadow.errors == 0 && shadow.due_replies.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            if (shadow.due_replies.size() != 0)
                $display("%0t: %0d expected replies never arrived", $time,
                         shadow.due_replies.size());
            $display("TEST FAILED");
        end
        $finish;
    end

    // Watchdog: a hung handshake ends the run here.
    initial begin : watchdog
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: sim.f
design/kvt_pkg.sv
design/kvt_cell.sv
design/key_value_table.sv
sim/tb_key_value_table.sv
